### src/ptw_pkg.sv
// shared types, constants and state codes for the page table walker
package ptw_pkg;

    localparam int OFFSET_BITS_D = 4;
    localparam int LEVELS_D      = 2;
    localparam int FRAME_COUNT_D = 16;
    localparam int PAGE_COUNT_D  = 256;
    localparam int WORD_BITS_D   = 32;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] virt_addr;
        logic [31:0] write_word;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_word;
    } t_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_SR_START,
        S_SR_RD,
        S_SR_CHK,
        S_SR_POP,
        S_TAKE,
        S_ZERO,
        S_EVICT_RD,
        S_EVICT_WR,
        S_LINK,
        S_RESTORE_RD,
        S_RESTORE_WR,
        S_ACCESS_RD,
        S_ACCESS_CHK,
        S_DONE
    } t_state;

endpackage

### src/page_table_walker_with_eviction_core.sv
// page table walker with free frame search and cyclic distance eviction
//
//  channel | signals                     | payload
//  request | i_req_valid / o_req_ready   | cmd, virt_addr, write_word
//  result  | o_rsp_valid / i_rsp_ready   | ok, read_word
//
// an out-of-range request goes from idle straight to the result; a mapped hit walks each level
// and then reads or writes the word. a miss adds a depth-first search over the table words,
// then may evict a page to swap, zero a new table frame or restore a held page, word by word
// after reset a clearing pass zeroes every word of the
// physical store; no request is taken meanwhile. the result waits in a
// register until taken and the next request is taken only after that.
module page_table_walker_with_eviction_core #(
    parameter int OFFSET_BITS = ptw_pkg::OFFSET_BITS_D,
    parameter int LEVELS      = ptw_pkg::LEVELS_D,
    parameter int FRAME_COUNT = ptw_pkg::FRAME_COUNT_D,
    parameter int PAGE_COUNT  = ptw_pkg::PAGE_COUNT_D,
    parameter int WORD_BITS   = ptw_pkg::WORD_BITS_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ptw_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ptw_pkg::t_rsp o_rsp
);

    localparam int PW   = 1 << OFFSET_BITS;
    localparam int OB   = OFFSET_BITS;
    localparam int FB   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int PB   = $clog2(PAGE_COUNT);
    localparam int PHD  = FRAME_COUNT * PW;
    localparam int PHA  = $clog2(PHD);
    localparam int SWD  = PAGE_COUNT * PW;
    localparam int SWA  = $clog2(SWD);
    localparam int LB   = $clog2(LEVELS + 1);
    localparam int TB   = LEVELS * OB;
    localparam int DB   = PB + 1;
    localparam int SDEP = LEVELS + 1;

    // physical store port
    logic              mem_we;
    logic [PHA-1:0]    mem_addr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

    ptw_mem #(.DEPTH(PHD), .WIDTH(WORD_BITS)) u_phys (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    logic              sw_we;
    logic [SWA-1:0]    sw_addr;
    logic [WORD_BITS-1:0] sw_rdata;

    ptw_mem #(.DEPTH(SWD), .WIDTH(WORD_BITS)) u_swap (
        .i_clk(i_clk), .i_we(sw_we), .i_addr(sw_addr),
        .i_wdata(mem_rdata), .o_rdata(sw_rdata)
    );

    ptw_pkg::t_state r_state, n_state;

    logic              r_cmd;
    logic [PB-1:0]     r_page;
    logic [TB-1:0]     r_tidx;
    logic [OB-1:0]     r_off;
    logic [WORD_BITS-1:0] r_wword;
    logic [PAGE_COUNT-1:0] r_held;

    logic [FB-1:0]     r_frame;     // current walk frame
    logic [LB-1:0]     r_lvl;       // current walk level
    logic [OB-1:0]     r_idx;       // walk slot
    logic [PHA:0]      r_cnt;       // sweep counter
    logic [FB-1:0]     r_newf;
    logic              r_pend_link; // a taken frame needs parent link clear

    // search stack of LEVELS+1 entries
    logic [FB-1:0]     r_sf    [SDEP];
    logic [OB:0]       r_ss    [SDEP];  // next slot
    logic              r_se    [SDEP];  // still empty
    logic [FB-1:0]     r_sp    [SDEP];
    logic [OB-1:0]     r_sps   [SDEP];
    logic [TB-1:0]     r_spg   [SDEP];
    logic [LB-1:0]     r_sl;            // stack depth

    logic [FB-1:0]     r_maxu;
    logic [DB-1:0]     r_best;
    logic [FB-1:0]     r_vf, r_vpar;
    logic [OB-1:0]     r_vslot;
    logic [TB-1:0]     r_vpg;
    logic              r_ef;
    logic [FB-1:0]     r_efr, r_epar;
    logic [OB-1:0]     r_eslot;
    logic              r_istab;

    logic              r_ok;
    logic [31:0]       r_rword;

    logic [FB:0]       link_v;
    logic [WORD_BITS-1:0] link_raw;
    logic [OB-1:0]     cur_idx;
    logic [DB-1:0]     dist_d, dist_w, cdist;
    logic [PB-1:0]     vpage_n;
    logic [FB-1:0]     top_f;
    logic [OB:0]       top_s;
    logic [FB:0]       maxp1;

    assign link_raw = mem_rdata;
    always_comb begin
        if (link_raw < WORD_BITS'(FRAME_COUNT)) link_v = (FB+1)'(link_raw);
        else link_v = '0;
    end

    assign cur_idx = r_tidx[(LEVELS-1-32'(r_lvl))*OB +: OB];
    assign top_f = r_sf[r_sl - LB'(1)];
    assign top_s = r_ss[r_sl - LB'(1)];
    assign maxp1 = {1'b0, r_maxu} + (FB+1)'(1);

    // cyclic distance of the leaf being entered
    assign vpage_n = PB'({r_spg[r_sl - LB'(1)], top_s[OB-1:0]});
    always_comb begin
        if (vpage_n > r_page) dist_d = DB'(vpage_n) - DB'(r_page);
        else dist_d = DB'(r_page) - DB'(vpage_n);
        dist_w = DB'(PAGE_COUNT) - dist_d;
        cdist = (dist_w < dist_d) ? dist_w : dist_d;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptw_pkg::S_CLEAR:
                if (r_cnt == (PHA+1)'(PHD - 1)) n_state = ptw_pkg::S_IDLE;
            ptw_pkg::S_IDLE:
                if (i_req_valid) begin
                    if (i_req.virt_addr >= 32'(SWD)) n_state = ptw_pkg::S_DONE;
                    else n_state = ptw_pkg::S_WALK_RD;
                end
            ptw_pkg::S_WALK_RD: n_state = ptw_pkg::S_WALK_CHK;
            ptw_pkg::S_WALK_CHK: begin
                if (link_v == '0) n_state = ptw_pkg::S_SR_START;
                else if (32'(r_lvl) == LEVELS - 1) n_state = ptw_pkg::S_RESTORE_RD;
                else n_state = ptw_pkg::S_WALK_RD;
            end
            ptw_pkg::S_SR_START: n_state = ptw_pkg::S_SR_RD;
            ptw_pkg::S_SR_RD: begin
                if (r_sl == '0) n_state = ptw_pkg::S_TAKE;
                else if (top_s == (OB+1)'(PW)) n_state = ptw_pkg::S_SR_POP;
                else n_state = ptw_pkg::S_SR_CHK;
            end
            ptw_pkg::S_SR_CHK: n_state = ptw_pkg::S_SR_RD;
            ptw_pkg::S_SR_POP: begin
                if (r_se[r_sl - LB'(1)] && top_f != r_frame) n_state = ptw_pkg::S_TAKE;
                else n_state = ptw_pkg::S_SR_RD;
            end
            ptw_pkg::S_TAKE: begin
                if (r_ef) n_state = ptw_pkg::S_LINK;
                else if (maxp1 < (FB+1)'(FRAME_COUNT))
                    n_state = r_istab ? ptw_pkg::S_ZERO : ptw_pkg::S_LINK;
                else if (r_vf == '0) n_state = ptw_pkg::S_DONE;
                else if (32'(r_vpg) < PAGE_COUNT) n_state = ptw_pkg::S_EVICT_RD;
                else n_state = r_istab ? ptw_pkg::S_ZERO : ptw_pkg::S_LINK;
            end
            ptw_pkg::S_EVICT_RD: n_state = ptw_pkg::S_EVICT_WR;
            ptw_pkg::S_EVICT_WR:
                if (r_cnt == (PHA+1)'(PW - 1))
                    n_state = r_istab ? ptw_pkg::S_ZERO : ptw_pkg::S_LINK;
                else n_state = ptw_pkg::S_EVICT_RD;
            ptw_pkg::S_ZERO:
                if (r_cnt == (PHA+1)'(PW - 1)) n_state = ptw_pkg::S_LINK;
            ptw_pkg::S_LINK:
                if (!r_pend_link) begin
                    if (32'(r_lvl) == LEVELS - 1) n_state = ptw_pkg::S_RESTORE_RD;
                    else n_state = ptw_pkg::S_WALK_RD;
                end
            ptw_pkg::S_RESTORE_RD:
                if (!r_held[r_page]) n_state = ptw_pkg::S_ACCESS_RD;
                else n_state = ptw_pkg::S_RESTORE_WR;
            ptw_pkg::S_RESTORE_WR:
                if (r_cnt == (PHA+1)'(PW - 1)) n_state = ptw_pkg::S_ACCESS_RD;
                else n_state = ptw_pkg::S_RESTORE_WR;
            ptw_pkg::S_ACCESS_RD: n_state = ptw_pkg::S_ACCESS_CHK;
            ptw_pkg::S_ACCESS_CHK: n_state = ptw_pkg::S_DONE;
            ptw_pkg::S_DONE: if (i_rsp_ready) n_state = ptw_pkg::S_IDLE;
            default: n_state = ptw_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        sw_we     = 1'b0;
        sw_addr   = SWA'({r_page, r_cnt[OB-1:0]});
        unique case (r_state)
            ptw_pkg::S_CLEAR: begin
                mem_we = 1'b1; mem_addr = r_cnt[PHA-1:0];
            end
            ptw_pkg::S_WALK_RD: mem_addr = PHA'({r_frame, cur_idx});
            ptw_pkg::S_SR_RD: mem_addr = PHA'({top_f, top_s[OB-1:0]});
            ptw_pkg::S_EVICT_RD: begin
                mem_addr = PHA'({r_vf, r_cnt[OB-1:0]});
                sw_addr  = SWA'({r_vpg[PB-1:0], r_cnt[OB-1:0]});
            end
            ptw_pkg::S_EVICT_WR: begin
                mem_addr = PHA'({r_vf, r_cnt[OB-1:0]});
                sw_we    = 1'b1;
                sw_addr  = SWA'({r_vpg[PB-1:0], r_cnt[OB-1:0]});
            end
            ptw_pkg::S_ZERO: begin
                mem_we = 1'b1; mem_addr = PHA'({r_newf, r_cnt[OB-1:0]});
            end
            ptw_pkg::S_LINK: begin
                mem_we = 1'b1;
                if (r_pend_link) begin
                    mem_addr = r_ef ? PHA'({r_epar, r_eslot}) : PHA'({r_vpar, r_vslot});
                end else begin
                    mem_addr  = PHA'({r_frame, cur_idx});
                    mem_wdata = WORD_BITS'(r_newf);
                end
            end
            ptw_pkg::S_RESTORE_RD: sw_addr = SWA'({r_page, OB'(0)});
            ptw_pkg::S_RESTORE_WR: begin
                mem_we    = 1'b1;
                mem_addr  = PHA'({r_frame, r_cnt[OB-1:0]});
                mem_wdata = sw_rdata;
                sw_addr   = SWA'({r_page, r_cnt[OB-1:0] + OB'(1)});
            end
            ptw_pkg::S_ACCESS_RD: begin
                mem_addr = PHA'({r_frame, r_off});
                mem_we   = (r_cmd == ptw_pkg::CMD_WRITE);
                mem_wdata = r_wword;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptw_pkg::S_CLEAR;
            r_cnt   <= '0;
            r_held  <= '0;
            r_sl    <= '0;
            r_pend_link <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ptw_pkg::S_CLEAR: r_cnt <= r_cnt + (PHA+1)'(1);
                ptw_pkg::S_IDLE: if (i_req_valid) begin
                    r_cmd   <= i_req.cmd;
                    r_page  <= PB'(i_req.virt_addr[31:OB]);
                    r_tidx  <= TB'(i_req.virt_addr[31:OB]);
                    r_off   <= i_req.virt_addr[OB-1:0];
                    r_wword <= WORD_BITS'(i_req.write_word);
                    r_frame <= '0;
                    r_lvl   <= '0;
                    r_ok    <= 1'b0;
                    r_rword <= '0;
                end
                ptw_pkg::S_WALK_CHK: if (link_v != '0) begin
                    r_frame <= FB'(link_v);
                    r_lvl   <= r_lvl + LB'(1);
                    r_cnt   <= '0;
                end
                ptw_pkg::S_SR_START: begin
                    r_istab <= (32'(r_lvl) != LEVELS - 1);
                    r_maxu  <= '0; r_best <= '0; r_vf <= '0; r_ef <= 1'b0;
                    r_vpg <= '0; r_vpar <= '0; r_vslot <= '0;
                    r_sl <= LB'(1);
                    r_sf[0] <= '0; r_ss[0] <= '0; r_se[0] <= 1'b1;
                    r_sp[0] <= '0; r_sps[0] <= '0; r_spg[0] <= '0;
                end
                ptw_pkg::S_SR_CHK: begin
                    r_ss[r_sl - LB'(1)] <= top_s + (OB+1)'(1);
                    if (link_v != '0) begin
                        r_se[r_sl - LB'(1)] <= 1'b0;
                        if (FB'(link_v) > r_maxu) r_maxu <= FB'(link_v);
                        if (32'(r_sl) == LEVELS) begin
                            if (cdist > r_best && FB'(link_v) != r_frame) begin
                                r_best <= cdist; r_vf <= FB'(link_v);
                                r_vpg <= TB'({r_spg[r_sl - LB'(1)], top_s[OB-1:0]});
                                r_vpar <= top_f; r_vslot <= top_s[OB-1:0];
                            end
                        end else begin
                            r_sf[r_sl] <= FB'(link_v); r_ss[r_sl] <= '0;
                            r_se[r_sl] <= 1'b1; r_sp[r_sl] <= top_f;
                            r_sps[r_sl] <= top_s[OB-1:0];
                            r_spg[r_sl] <= TB'({r_spg[r_sl - LB'(1)], top_s[OB-1:0]});
                            r_sl <= r_sl + LB'(1);
                        end
                    end
                end
                ptw_pkg::S_SR_POP: begin
                    if (r_se[r_sl - LB'(1)] && top_f != r_frame) begin
                        r_ef <= 1'b1; r_efr <= top_f;
                        r_epar <= r_sp[r_sl - LB'(1)]; r_eslot <= r_sps[r_sl - LB'(1)];
                    end
                    r_sl <= r_sl - LB'(1);
                end
                ptw_pkg::S_TAKE: begin
                    r_sl  <= '0;
                    r_cnt <= '0;
                    if (r_ef) begin
                        r_newf <= r_efr; r_pend_link <= 1'b1;
                    end else if (maxp1 < (FB+1)'(FRAME_COUNT)) begin
                        r_newf <= FB'(maxp1);
                    end else begin
                        r_newf <= r_vf; r_pend_link <= (r_vf != '0);
                        if (r_vf != '0 && 32'(r_vpg) < PAGE_COUNT)
                            r_held[r_vpg[PB-1:0]] <= 1'b1;
                    end
                end
                ptw_pkg::S_EVICT_WR:
                    r_cnt <= (r_cnt == (PHA+1)'(PW - 1)) ? '0 : r_cnt + (PHA+1)'(1);
                ptw_pkg::S_ZERO:
                    r_cnt <= (r_cnt == (PHA+1)'(PW - 1)) ? '0 : r_cnt + (PHA+1)'(1);
                ptw_pkg::S_LINK: begin
                    if (r_pend_link) r_pend_link <= 1'b0;
                    else begin
                        r_frame <= r_newf;
                        r_lvl   <= r_lvl + LB'(1);
                        r_cnt   <= '0;
                    end
                end
                ptw_pkg::S_RESTORE_WR: begin
                    r_cnt <= r_cnt + (PHA+1)'(1);
                    if (r_cnt == (PHA+1)'(PW - 1)) r_held[r_page] <= 1'b0;
                end
                ptw_pkg::S_ACCESS_CHK: begin
                    r_ok <= 1'b1;
                    if (r_cmd == ptw_pkg::CMD_READ)
                        r_rword <= 32'($signed(mem_rdata));
                end
                default: ;
            endcase
        end
    end

    assign o_req_ready     = (r_state == ptw_pkg::S_IDLE);
    assign o_rsp_valid     = (r_state == ptw_pkg::S_DONE);
    assign o_rsp.ok        = r_ok;
    assign o_rsp.read_word = r_rword;

endmodule

### src/ptw_mem.sv
// single port word store with registered read
module ptw_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
